// File: src/hht_pkg.sv
// shared types, codes and character constants for the http header tokenizer
package hht_pkg;

    // fixed widths of the beat fields
    localparam int DATA_W  = 8;
    localparam int KIND_W  = 3;
    localparam int START_W = 13;
    localparam int LEN_W   = 14;
    localparam int FNUM_W  = 5;
    localparam int STAT_W  = 2;

    // token kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_METHOD  = 3'd0,
        KIND_URI     = 3'd1,
        KIND_VERSION = 3'd2,
        KIND_CODE    = 3'd3,
        KIND_REASON  = 3'd4,
        KIND_KEY     = 3'd5,
        KIND_VALUE   = 3'd6,
        KIND_FINAL   = 3'd7
    } t_kind;

    // parse status codes on the final beat
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_TOO_MANY  = 2'd2,
        ST_TOO_LONG  = 2'd3
    } t_status;

    // parser phases
    typedef enum logic [3:0] {
        PH_TOK1       = 4'd0,
        PH_TOK2       = 4'd1,
        PH_TOK3       = 4'd2,
        PH_START_LF   = 4'd3,
        PH_FIRST_LINE = 4'd4,
        PH_LINE       = 4'd5,
        PH_LINE_CR    = 4'd6,
        PH_KEY        = 4'd7,
        PH_SKIP       = 4'd8,
        PH_VALUE      = 4'd9
    } t_phase;

    // one result beat
    typedef struct packed {
        t_kind               kind;
        logic [START_W-1:0]  start;
        logic [LEN_W-1:0]    length;
        logic [FNUM_W-1:0]   field_number;
        logic                is_response;
        t_status             status;
        logic                last;
    } t_result;

    // characters
    localparam logic [DATA_W-1:0] CH_NUL   = 8'h00;
    localparam logic [DATA_W-1:0] CH_TAB   = 8'h09;
    localparam logic [DATA_W-1:0] CH_LF    = 8'h0A;
    localparam logic [DATA_W-1:0] CH_VT    = 8'h0B;
    localparam logic [DATA_W-1:0] CH_FF    = 8'h0C;
    localparam logic [DATA_W-1:0] CH_CR    = 8'h0D;
    localparam logic [DATA_W-1:0] CH_SP    = 8'h20;
    localparam logic [DATA_W-1:0] CH_COLON = 8'h3A;

    // status line prefix "HTTP"
    localparam logic [DATA_W-1:0] HTTP_PREFIX [4] = '{8'h48, 8'h54, 8'h54, 8'h50};

    // whitespace class used at line and value starts
    function automatic logic is_ws(input logic [DATA_W-1:0] b);
        return (b == CH_SP) || (b == CH_TAB) || (b == CH_LF) || (b == CH_VT) ||
               (b == CH_FF) || (b == CH_CR);
    endfunction

endpackage

// File: src/hht_if.sv
// stream interfaces for header bytes in and token beats out

interface hht_byte_if;
    logic                       valid;
    logic                       ready;
    logic [hht_pkg::DATA_W-1:0] data_byte;
    logic                       byte_last;

    modport source (output valid, output data_byte, output byte_last, input ready);
    modport sink   (input valid, input data_byte, input byte_last, output ready);
endinterface

interface hht_token_if;
    logic                        valid;
    logic                        ready;
    logic [hht_pkg::KIND_W-1:0]  token_kind;
    logic [hht_pkg::START_W-1:0] token_start;
    logic [hht_pkg::LEN_W-1:0]   token_length;
    logic [hht_pkg::FNUM_W-1:0]  field_number;
    logic                        is_response;
    logic [hht_pkg::STAT_W-1:0]  parse_status;
    logic                        result_last;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output field_number, output is_response,
                    output parse_status, output result_last, input ready);
    modport sink   (input valid, input token_kind, input token_start,
                    input token_length, input field_number, input is_response,
                    input parse_status, input result_last, output ready);
endinterface

// File: src/http_header_tokenizer.sv
// an accepted byte is held in the input register, and its result beats are registered in the queue
// throughput: one byte per cycle while the queue has room; each byte is decided combinationally in the parser core
// a byte yields at most two beats; the four-entry queue holds input while it has < 2 free
// reset: synchronous active low, parser back to the first start-line token, queue emptied
// a byte with the last mark also returns the parser to its initial state
module http_header_tokenizer #(
    parameter int MAX_FIELDS = 32,
    parameter int MAX_BYTES  = 8192
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hht_byte_if.sink      i_byte,
    hht_token_if.source   o_token
);
    import hht_pkg::*;

    logic                r_in_valid;
    logic [DATA_W-1:0]   r_in_byte;
    logic                r_in_last;
    logic                advance;
    logic                room2;
    logic                res0_valid, res1_valid;
    t_result             res0, res1;
    logic                q_valid;
    t_result             q_item;

    // input register stage
    assign advance      = r_in_valid && room2;
    assign i_byte.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.data_byte;
            r_in_last <= i_byte.byte_last;
        end
    end

    // parser
    hht_core #(
        .MAX_FIELDS (MAX_FIELDS),
        .MAX_BYTES  (MAX_BYTES)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (advance),
        .i_data_byte  (r_in_byte),
        .i_byte_last  (r_in_last),
        .o_res0_valid (res0_valid),
        .o_res0       (res0),
        .o_res1_valid (res1_valid),
        .o_res1       (res1)
    );

    // result queue
    hht_outq u_outq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push0_valid (res0_valid),
        .i_push0       (res0),
        .i_push1_valid (res1_valid),
        .i_push1       (res1),
        .o_room2       (room2),
        .o_valid       (q_valid),
        .o_item        (q_item),
        .i_ready       (o_token.ready)
    );

    // output beat
    assign o_token.valid        = q_valid;
    assign o_token.token_kind   = q_item.kind;
    assign o_token.token_start  = q_item.start;
    assign o_token.token_length = q_item.length;
    assign o_token.field_number = q_item.field_number;
    assign o_token.is_response  = q_item.is_response;
    assign o_token.parse_status = q_item.status;
    assign o_token.result_last  = q_item.last;

endmodule

// File: src/hht_core.sv
// parser state and per-byte decision logic, up to two result beats per byte
module hht_core #(
    parameter int MAX_FIELDS = 32,
    parameter int MAX_BYTES  = 8192
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [hht_pkg::DATA_W-1:0] i_data_byte,
    input  logic                       i_byte_last,
    output logic                       o_res0_valid,
    output hht_pkg::t_result           o_res0,
    output logic                       o_res1_valid,
    output hht_pkg::t_result           o_res1
);
    import hht_pkg::*;

    localparam int OFF_W = $clog2(MAX_BYTES + 1);
    localparam int FLD_W = $clog2(MAX_FIELDS + 1);

    t_phase             r_phase,  n_phase;
    logic [OFF_W-1:0]   r_off,    n_off;
    logic [OFF_W-1:0]   r_cts,    n_cts;
    logic [2:0]         r_pmc,    n_pmc;
    logic               r_resp,   n_resp;
    logic [FLD_W-1:0]   r_fields, n_fields;
    logic               r_pcr,    n_pcr;
    logic               r_done,   n_done;

    logic               tok_v;
    t_result            tok;
    logic               fin_v;
    t_result            fin;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TOK1;
            r_off    <= '0;
            r_cts    <= '0;
            r_pmc    <= '0;
            r_resp   <= 1'b0;
            r_fields <= '0;
            r_pcr    <= 1'b0;
            r_done   <= 1'b0;
        end else if (i_valid) begin
            r_phase  <= n_phase;
            r_off    <= n_off;
            r_cts    <= n_cts;
            r_pmc    <= n_pmc;
            r_resp   <= n_resp;
            r_fields <= n_fields;
            r_pcr    <= n_pcr;
            r_done   <= n_done;
        end
    end

    // per-byte decision
    always_comb begin
        logic             bad;
        logic             mid_fin;
        t_status          mid_status;
        logic             do_key;
        logic [OFF_W-1:0] key_s;
        logic             resp_now;
        logic [DATA_W-1:0] b;

        b          = i_data_byte;
        bad        = 1'b0;
        mid_fin    = 1'b0;
        mid_status = ST_OK;
        do_key     = 1'b0;
        key_s      = r_off;
        resp_now   = r_resp;

        n_phase  = r_phase;
        n_off    = r_off;
        n_cts    = r_cts;
        n_pmc    = r_pmc;
        n_resp   = r_resp;
        n_fields = r_fields;
        n_pcr    = r_pcr;
        n_done   = r_done;

        tok_v = 1'b0;
        tok   = '{kind: KIND_METHOD, status: ST_OK, default: '0};
        fin_v = 1'b0;
        fin   = '{kind: KIND_FINAL, status: ST_OK, default: '0};

        if (r_done) begin
            // ignore bytes until the buffer's last mark
        end else if (r_off >= OFF_W'(MAX_BYTES)) begin
            mid_fin    = 1'b1;
            mid_status = ST_TOO_LONG;
        end else begin
            // status line prefix match
            if (r_phase == PH_TOK1 && r_off < OFF_W'(4) && OFF_W'(r_pmc) == r_off &&
                b == HTTP_PREFIX[r_off[1:0]]) begin
                n_pmc = r_pmc + 3'd1;
                if (r_pmc == 3'd3) begin
                    resp_now = 1'b1;
                end
            end
            n_resp = resp_now;

            case (r_phase)
                PH_TOK1, PH_TOK2: begin
                    if (b == CH_NUL || (r_pcr && b == CH_LF)) begin
                        bad = 1'b1;
                    end else if (b == CH_SP) begin
                        tok_v        = 1'b1;
                        tok.kind     = (r_phase == PH_TOK1)
                                       ? (resp_now ? KIND_VERSION : KIND_METHOD)
                                       : (resp_now ? KIND_CODE : KIND_URI);
                        tok.start    = START_W'(r_cts);
                        tok.length   = LEN_W'(r_off - r_cts);
                        n_cts        = r_off + OFF_W'(1);
                        n_pcr        = 1'b0;
                        n_phase      = (r_phase == PH_TOK1) ? PH_TOK2 : PH_TOK3;
                    end else begin
                        n_pcr = (b == CH_CR);
                    end
                end
                PH_TOK3: begin
                    if (b == CH_NUL) begin
                        bad = 1'b1;
                    end else if (b == CH_CR) begin
                        tok_v      = 1'b1;
                        tok.kind   = resp_now ? KIND_REASON : KIND_VERSION;
                        tok.start  = START_W'(r_cts);
                        tok.length = LEN_W'(r_off - r_cts);
                        n_phase    = PH_START_LF;
                    end
                end
                PH_START_LF: begin
                    if (b == CH_LF) begin
                        n_phase = PH_FIRST_LINE;
                    end else begin
                        bad = 1'b1;
                    end
                end
                PH_FIRST_LINE: begin
                    if (is_ws(b)) begin
                        bad = 1'b1;
                    end else begin
                        do_key = 1'b1;
                    end
                end
                PH_LINE: begin
                    if (b == CH_CR) begin
                        n_phase = PH_LINE_CR;
                    end else begin
                        do_key = 1'b1;
                    end
                end
                PH_LINE_CR: begin
                    if (b == CH_LF) begin
                        mid_fin    = 1'b1;
                        mid_status = ST_OK;
                    end else begin
                        // the pending cr opens the key
                        do_key = 1'b1;
                        key_s  = r_off - OFF_W'(1);
                    end
                end
                PH_KEY: begin
                    if (b == CH_COLON) begin
                        tok_v            = 1'b1;
                        tok.kind         = KIND_KEY;
                        tok.start        = START_W'(r_cts);
                        tok.length       = LEN_W'(r_off - r_cts);
                        tok.field_number = FNUM_W'(r_fields - FLD_W'(1));
                        n_pcr            = 1'b0;
                        n_phase          = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    if (r_pcr && b == CH_LF) begin
                        bad = 1'b1;
                    end else if (b == CH_CR) begin
                        n_pcr = 1'b1;
                    end else begin
                        n_pcr = 1'b0;
                        if (!is_ws(b)) begin
                            if (i_byte_last) begin
                                bad = 1'b1;
                            end else begin
                                n_cts   = r_off;
                                n_phase = PH_VALUE;
                            end
                        end
                    end
                end
                PH_VALUE: begin
                    if (r_pcr && b == CH_LF) begin
                        tok_v            = 1'b1;
                        tok.kind         = KIND_VALUE;
                        tok.start        = START_W'(r_cts);
                        tok.length       = LEN_W'(r_off - OFF_W'(1) - r_cts);
                        tok.field_number = FNUM_W'(r_fields - FLD_W'(1));
                        n_pcr            = 1'b0;
                        n_phase          = PH_LINE;
                    end else begin
                        n_pcr = (b == CH_CR);
                    end
                end
                default: begin
                    bad = 1'b1;
                end
            endcase

            // key start on a line
            if (do_key) begin
                if (r_fields >= FLD_W'(MAX_FIELDS)) begin
                    mid_fin    = 1'b1;
                    mid_status = ST_TOO_MANY;
                end else begin
                    n_fields = r_fields + FLD_W'(1);
                    n_cts    = key_s;
                    n_pcr    = 1'b0;
                    n_phase  = PH_KEY;
                    if (b == CH_COLON) begin
                        tok_v            = 1'b1;
                        tok.kind         = KIND_KEY;
                        tok.start        = START_W'(key_s);
                        tok.length       = LEN_W'(r_off - key_s);
                        tok.field_number = FNUM_W'(r_fields);
                        n_phase          = PH_SKIP;
                    end
                end
            end
            n_off = r_off + OFF_W'(1);
        end

        // final beat: explicit finish, error, or end of buffer
        if (!r_done) begin
            if (mid_fin) begin
                fin_v      = 1'b1;
                fin.status = mid_status;
            end else if (bad) begin
                fin_v      = 1'b1;
                fin.status = ST_MALFORMED;
            end else if (i_byte_last) begin
                fin_v      = 1'b1;
                fin.status = (n_phase == PH_LINE) ? ST_OK : ST_MALFORMED;
            end
        end
        if (fin_v) begin
            n_done = 1'b1;
        end
        tok.is_response = resp_now;
        fin.is_response = resp_now;
        fin.last        = 1'b1;

        // last mark returns to the initial state
        if (i_byte_last) begin
            n_phase  = PH_TOK1;
            n_off    = '0;
            n_cts    = '0;
            n_pmc    = '0;
            n_resp   = 1'b0;
            n_fields = '0;
            n_pcr    = 1'b0;
            n_done   = 1'b0;
        end
    end

    // order beats: token first, then the final beat
    always_comb begin
        o_res0_valid = i_valid && (tok_v || fin_v);
        o_res0       = tok_v ? tok : fin;
        o_res1_valid = i_valid && tok_v && fin_v;
        o_res1       = fin;
    end

endmodule

// File: src/hht_outq.sv
// small result queue taking up to two beats per cycle and giving one
module hht_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push0_valid,
    input  hht_pkg::t_result i_push0,
    input  logic             i_push1_valid,
    input  hht_pkg::t_result i_push1,
    output logic             o_room2,
    output logic             o_valid,
    output hht_pkg::t_result o_item,
    input  logic             i_ready
);
    import hht_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_result          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             pop;
    logic [CNT_W-1:0] push_n;

    // pointer and count bookkeeping
    always_comb begin
        pop    = o_valid && i_ready;
        push_n = CNT_W'(i_push0_valid) + CNT_W'(i_push1_valid);
        n_wr   = r_wr + PTR_W'(push_n);
        n_rd   = r_rd + PTR_W'(pop);
        n_cnt  = r_cnt + push_n - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // entry writes
    always_ff @(posedge i_clk) begin
        if (i_push0_valid) begin
            r_mem[r_wr] <= i_push0;
        end
        if (i_push1_valid) begin
            r_mem[r_wr + PTR_W'(1)] <= i_push1;
        end
    end

    assign o_room2 = (r_cnt <= CNT_W'(DEPTH - 2));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];

endmodule

// File: src/hht_checker.sv
// port-level checks on the token stream, bound to the top level
module hht_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        i_ready,
    input  logic [hht_pkg::KIND_W-1:0]  i_kind,
    input  logic [hht_pkg::START_W-1:0] i_start,
    input  logic [hht_pkg::LEN_W-1:0]   i_length,
    input  logic [hht_pkg::FNUM_W-1:0]  i_fnum,
    input  logic                        i_resp,
    input  logic [hht_pkg::STAT_W-1:0]  i_status,
    input  logic                        i_last
);
    import hht_pkg::*;

    // a stalled beat stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("token beat dropped while stalled");

    // a stalled beat keeps its payload
    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_kind) && $stable(i_start) &&
        $stable(i_length) && $stable(i_fnum) && $stable(i_resp) &&
        $stable(i_status) && $stable(i_last))
        else $error("token payload changed while stalled");

    // the last flag marks exactly the final beat
    a_last_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_last == (i_kind == KIND_FINAL)))
        else $error("last flag and final kind disagree");

    // the final beat carries no token span
    a_final_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_last |-> i_start == '0 && i_length == '0 && i_fnum == '0)
        else $error("final beat carries a span");

    // token beats carry ok status, and only key and value carry a field number
    a_token_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_last |-> i_status == ST_OK &&
        (i_fnum == '0 || i_kind == KIND_KEY || i_kind == KIND_VALUE))
        else $error("token beat carries status or stray field number");

endmodule

bind http_header_tokenizer hht_checker u_hht_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_token.valid),
    .i_ready  (o_token.ready),
    .i_kind   (o_token.token_kind),
    .i_start  (o_token.token_start),
    .i_length (o_token.token_length),
    .i_fnum   (o_token.field_number),
    .i_resp   (o_token.is_response),
    .i_status (o_token.parse_status),
    .i_last   (o_token.result_last)
);
